// File: rtl/itf_pkg.sv
// ----------------------------------------------------------------------------
// itf_pkg: shared definitions for the integer-to-text formatter
// Constants, flag bit positions, controller/datapath interface structs and
// the digit-to-ASCII mapping.
// ----------------------------------------------------------------------------
package itf_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_FIELD_DEF  = 60;

  // longest text emitted for one item
  localparam int MAX_OUT        = 64;
  // width of the layout arithmetic (field lengths, boundaries)
  localparam int LEN_W          = 8;
  // quotient bits produced per divider cycle
  localparam int DIV_RADIX_BITS = 4;

  localparam logic [5:0] BASE_MIN       = 6'd2;
  localparam logic [5:0] BASE_MAX       = 6'd36;
  localparam logic [5:0] BASE_OCT       = 6'd8;
  localparam logic [5:0] BASE_HEX       = 6'd16;
  localparam logic [5:0] PREFIX_X_DIGIT = 6'd33;

  // format_flags bit positions
  localparam int FLAG_ZERO   = 0;
  localparam int FLAG_SIGNED = 1;
  localparam int FLAG_PLUS   = 2;
  localparam int FLAG_SPACE  = 3;
  localparam int FLAG_LEFT   = 4;
  localparam int FLAG_PREFIX = 5;
  localparam int FLAG_LOWER  = 6;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_UPPER = 8'h41;
  localparam logic [7:0] CHAR_LOWER = 8'h61;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  typedef struct packed {
    logic load;      // capture a new item
    logic div_step;  // advance the digit divider
    logic layout;    // compute segment boundaries
    logic emit;      // issue the next character position
    logic emit_bad;  // issue the single bad-base result
  } itf_cmd_t;

  typedef struct packed {
    logic bad_base;   // captured base outside 2..36
    logic div_last;   // this divider cycle finishes a digit
    logic quot_zero;  // quotient after this digit is zero
    logic emit_last;  // current position is the final character
  } itf_status_t;

  // digit value 0..35 to ASCII
  function automatic logic [7:0] digit_char(input logic [5:0] d, input logic lower);
    logic [7:0] alpha;
    alpha = lower ? CHAR_LOWER : CHAR_UPPER;
    if (d < 6'd10) begin
      digit_char = CHAR_ZERO + {2'b00, d};
    end else begin
      digit_char = alpha + {2'b00, d} - 8'd10;
    end
  endfunction

endpackage

// File: rtl/itf_ctrl.sv
// ----------------------------------------------------------------------------
// itf_ctrl: sequencing controller for the integer-to-text formatter
// Steps through capture, base check, digit extraction, layout and emission.
// ----------------------------------------------------------------------------
module itf_ctrl
  import itf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  output itf_cmd_t    cmd_o,
  input  itf_status_t status_i
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_LAYOUT = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;
  localparam logic [2:0] ST_DRAIN  = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.bad_base) begin
          cmd_o.emit_bad = 1'b1;
          state_d        = ST_DRAIN;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last && status_i.quot_zero) begin
          state_d = ST_LAYOUT;
        end
      end
      ST_LAYOUT: begin
        cmd_o.layout = 1'b1;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        if (status_i.emit_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last character still in the two-stage output pipe
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> state_q == ST_IDLE && start_i)
    else $error("load issued outside idle");

  a_emit_then_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit && status_i.emit_last |=> state_q == ST_DRAIN && !cmd_o.emit)
    else $error("emission continued past last character");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command");

endmodule

// File: rtl/itf_datapath.sv
// ----------------------------------------------------------------------------
// itf_datapath: datapath of the integer-to-text formatter
// Input capture, radix-16 digit divider, digit memory, layout and the
// two-stage character output pipe.
// ----------------------------------------------------------------------------
module itf_datapath
  import itf_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int MAX_FIELD  = MAX_FIELD_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  itf_cmd_t    cmd_i,
  output itf_status_t status_o,
  input  logic [31:0] value_i,
  input  logic [5:0]  base_i,
  input  logic [5:0]  width_i,
  input  logic [5:0]  precision_i,
  input  logic [6:0]  format_flags_i,
  output logic        valid_o,
  output logic [7:0]  character_o,
  output logic        last_o,
  output logic        bad_base_o
);

  localparam int DIV_CYC = (VALUE_BITS + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
  localparam int QW      = DIV_CYC * DIV_RADIX_BITS;
  localparam int SW      = $clog2(DIV_CYC);
  localparam int AW      = $clog2(VALUE_BITS);
  localparam int NDW     = $clog2(VALUE_BITS + 1);
  localparam int KW      = $clog2(MAX_OUT);

  localparam logic [2:0] SEL_SPACE = 3'd0;
  localparam logic [2:0] SEL_SIGN  = 3'd1;
  localparam logic [2:0] SEL_ZERO  = 3'd2;
  localparam logic [2:0] SEL_XCHAR = 3'd3;
  localparam logic [2:0] SEL_DIGIT = 3'd4;
  localparam logic [2:0] SEL_BAD   = 3'd5;

  // captured item
  logic [5:0]   base_q, size_q, prec_q;
  logic [6:0]   flags_q;
  logic         neg_q;
  // divider
  logic [QW-1:0] work_q, work_next;
  logic [5:0]    rem_q, rem_next;
  logic [SW-1:0] step_q;
  logic [NDW-1:0] nd_q;
  // layout boundaries
  logic [LEN_W-1:0] b1_q, b2_q, b3_q, b5_q, b6_q, len_q;
  logic [LEN_W-1:0] b1_d, b2_d, b3_d, b5_d, b6_d, len_d;
  logic [KW-1:0]    k_q;
  // output pipe
  logic         a_valid_q, a_last_q;
  logic [2:0]   a_sel_q, sel_d;
  logic [5:0]   rdata_q;
  logic         out_valid_q, out_last_q, out_bad_q;
  logic [7:0]   out_char_q, char_d;

  logic [5:0]   digit_mem [VALUE_BITS];
  logic [AW-1:0] rd_addr;
  logic [LEN_W-1:0] kk, dig_idx;

  logic [VALUE_BITS-1:0] num, mag;
  logic                  is_neg;
  logic                  div_last, emit_last;

  // ---------------- capture ----------------
  assign num    = VALUE_BITS'(value_i);
  assign is_neg = format_flags_i[FLAG_SIGNED] & num[VALUE_BITS-1];
  assign mag    = is_neg ? (VALUE_BITS'(0) - num) : num;

  // ---------------- divider: DIV_RADIX_BITS quotient bits per cycle ------
  always_comb begin
    logic [DIV_RADIX_BITS-1:0] bits, qbits;
    logic [6:0] trial;
    logic [5:0] r;
    bits  = work_q[QW-1 -: DIV_RADIX_BITS];
    r     = rem_q;
    qbits = '0;
    for (int i = DIV_RADIX_BITS - 1; i >= 0; i--) begin
      trial = {r, bits[i]};
      if (trial >= {1'b0, base_q}) begin
        r        = 6'(trial - {1'b0, base_q});
        qbits[i] = 1'b1;
      end else begin
        r = trial[5:0];
      end
    end
    rem_next  = r;
    work_next = {work_q[QW-DIV_RADIX_BITS-1:0], qbits};
  end

  assign div_last = (step_q == SW'(DIV_CYC - 1));

  // ---------------- layout ----------------
  always_comb begin
    logic             zero_eff, left, s_en, pfx8, pfx16;
    logic [LEN_W-1:0] size0, size1, size2, precp, nd_w, padn, plen, lead, zpad, trail;
    logic [LEN_W-1:0] b4, total;
    left     = flags_q[FLAG_LEFT];
    zero_eff = flags_q[FLAG_ZERO];  // left already cleared it at capture
    s_en     = neg_q | flags_q[FLAG_PLUS] | flags_q[FLAG_SPACE];
    pfx16    = flags_q[FLAG_PREFIX] && (base_q == BASE_HEX);
    pfx8     = flags_q[FLAG_PREFIX] && (base_q == BASE_OCT);
    size0    = LEN_W'(size_q);
    nd_w     = LEN_W'(nd_q);
    size1    = (s_en && size0 != '0) ? size0 - 1'b1 : size0;
    if (pfx16) begin
      size2 = (size1 >= LEN_W'(2)) ? size1 - LEN_W'(2) : size1;
      plen  = LEN_W'(2);
    end else if (pfx8) begin
      size2 = (size1 != '0) ? size1 - 1'b1 : size1;
      plen  = LEN_W'(1);
    end else begin
      size2 = size1;
      plen  = '0;
    end
    precp = (nd_w > LEN_W'(prec_q)) ? nd_w : LEN_W'(prec_q);
    padn  = (size2 > precp) ? size2 - precp : '0;
    lead  = (!zero_eff && !left) ? padn : '0;
    zpad  = zero_eff ? padn : '0;
    trail = left ? padn : '0;
    b1_d  = lead;
    b2_d  = b1_d + LEN_W'(s_en);
    b3_d  = b2_d + plen;
    b4    = b3_d + zpad;
    b5_d  = b4 + (precp - nd_w);
    b6_d  = b4 + precp;
    total = b6_d + trail;
    len_d = (total > LEN_W'(MAX_OUT)) ? LEN_W'(MAX_OUT) : total;
  end

  // ---------------- character selection (stage A) ----------------
  assign kk        = LEN_W'(k_q);
  assign emit_last = (kk == len_q - 1'b1);
  assign dig_idx   = b6_q - 1'b1 - kk;
  assign rd_addr   = dig_idx[AW-1:0];

  always_comb begin
    if (kk < b1_q) begin
      sel_d = SEL_SPACE;
    end else if (kk < b2_q) begin
      sel_d = SEL_SIGN;
    end else if (kk < b3_q) begin
      sel_d = (kk == b2_q) ? SEL_ZERO : SEL_XCHAR;
    end else if (kk < b5_q) begin
      sel_d = SEL_ZERO;
    end else if (kk < b6_q) begin
      sel_d = SEL_DIGIT;
    end else begin
      sel_d = SEL_SPACE;
    end
  end

  // ---------------- character forming (stage B) ----------------
  always_comb begin
    case (a_sel_q)
      SEL_SPACE: char_d = CHAR_SPACE;
      SEL_SIGN:  char_d = neg_q ? CHAR_MINUS
                        : (flags_q[FLAG_PLUS] ? CHAR_PLUS : CHAR_SPACE);
      SEL_ZERO:  char_d = CHAR_ZERO;
      SEL_XCHAR: char_d = digit_char(PREFIX_X_DIGIT, flags_q[FLAG_LOWER]);
      SEL_DIGIT: char_d = digit_char(rdata_q, flags_q[FLAG_LOWER]);
      SEL_BAD:   char_d = CHAR_NUL;
      default:   char_d = CHAR_NUL;
    endcase
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      nd_q        <= '0;
      k_q         <= '0;
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        step_q <= '0;
        nd_q   <= '0;
      end else if (cmd_i.div_step) begin
        if (div_last) begin
          step_q <= '0;
          nd_q   <= nd_q + 1'b1;
        end else begin
          step_q <= step_q + 1'b1;
        end
      end
      if (cmd_i.layout) begin
        k_q <= '0;
      end else if (cmd_i.emit) begin
        k_q <= k_q + 1'b1;
      end
      a_valid_q   <= cmd_i.emit | cmd_i.emit_bad;
      out_valid_q <= a_valid_q;
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      base_q  <= base_i;
      size_q  <= (width_i > 6'(MAX_FIELD)) ? 6'(MAX_FIELD) : width_i;
      prec_q  <= (precision_i > 6'(MAX_FIELD)) ? 6'(MAX_FIELD) : precision_i;
      flags_q <= format_flags_i & ~(7'(format_flags_i[FLAG_LEFT]) << FLAG_ZERO);
      neg_q   <= is_neg;
      work_q  <= QW'(mag);
      rem_q   <= '0;
    end else if (cmd_i.div_step) begin
      work_q <= work_next;
      rem_q  <= div_last ? 6'd0 : rem_next;
    end
    if (cmd_i.layout) begin
      b1_q  <= b1_d;
      b2_q  <= b2_d;
      b3_q  <= b3_d;
      b5_q  <= b5_d;
      b6_q  <= b6_d;
      len_q <= len_d;
    end
    a_sel_q    <= cmd_i.emit_bad ? SEL_BAD : sel_d;
    a_last_q   <= cmd_i.emit_bad | emit_last;
    out_char_q <= char_d;
    out_last_q <= a_last_q;
    out_bad_q  <= (a_sel_q == SEL_BAD);
  end

  // ---------------- digit memory ----------------
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_step && div_last) begin
      digit_mem[nd_q[AW-1:0]] <= rem_next;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= digit_mem[rd_addr];
  end

  assign status_o.bad_base  = (base_q < BASE_MIN) || (base_q > BASE_MAX);
  assign status_o.div_last  = div_last;
  assign status_o.quot_zero = (work_next == '0);
  assign status_o.emit_last = emit_last;

  assign valid_o     = out_valid_q;
  assign character_o = out_char_q;
  assign last_o      = out_last_q;
  assign bad_base_o  = out_bad_q;

  a_bad_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_bad_q |-> out_last_q)
    else $error("bad-base result without last");

  a_digit_below_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step && div_last |-> rem_next < base_q && nd_q < NDW'(VALUE_BITS))
    else $error("digit out of range or digit store overflow");

  a_pos_in_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> kk < len_q)
    else $error("character position past text length");

endmodule

// File: rtl/integer_to_text_formatter.sv
// ----------------------------------------------------------------------------
// integer_to_text_formatter: printf-style integer to ASCII text
// Converts one integer in base 2..36 with width, precision and format flags
// into a stream of characters, one per strobe, the final one marked last.
// ----------------------------------------------------------------------------
//
//  channel   | handshake              | payload
//  ----------+------------------------+----------------------------------------
//  input     | start_i, busy_o        | value_i, base_i, width_i, precision_i,
//            |                        | format_flags_i
//  result    | valid_o (1-cycle)      | character_o, last_o, bad_base_o
//
//  An item is taken when start_i is high and busy_o is low; busy_o falls at
//  the edge that puts the last character on the result ports, so that strobe
//  comes in the first idle cycle.
//  The digit divider retires 4 quotient bits per cycle and passes over the
//  whole quotient register for each digit; emission then runs one
//  character per cycle. A bad base yields one result with bad_base_o set.
//  Reset (rst_ni low, asynchronous) returns the controller to idle and drops
//  any pending strobe. The receiver cannot stall: each result is valid for
//  exactly one cycle.
//
module integer_to_text_formatter
  import itf_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int MAX_FIELD  = MAX_FIELD_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] value_i,
  input  logic [5:0]  base_i,
  input  logic [5:0]  width_i,
  input  logic [5:0]  precision_i,
  input  logic [6:0]  format_flags_i,
  output logic        valid_o,
  output logic [7:0]  character_o,
  output logic        last_o,
  output logic        bad_base_o
);

  itf_cmd_t    cmd;
  itf_status_t status;

  // sequencer: capture, check, divide, layout, emit, drain
  itf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .cmd_o    (cmd),
    .status_i (status)
  );

  // divider, digit store and character pipe
  itf_datapath #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_FIELD  (MAX_FIELD)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .value_i        (value_i),
    .base_i         (base_i),
    .width_i        (width_i),
    .precision_i    (precision_i),
    .format_flags_i (format_flags_i),
    .valid_o        (valid_o),
    .character_o    (character_o),
    .last_o         (last_o),
    .bad_base_o     (bad_base_o)
  );

  // no result strobe may follow a last character in the very next cycle
  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |=> !valid_o)
    else $error("result strobe right after last character");

  // every accepted item makes the block busy
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("item accepted but block not busy");

  // no results appear while idle except the tail of the previous item
  a_no_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o && !$past(busy_o) && !$past(busy_o, 2) |-> !valid_o)
    else $error("result strobe without an item in flight");

endmodule

// File: bench/integer_to_text_formatter_test.sv
// ----------------------------------------------------------------------------
// integer_to_text_formatter_test: self-checking bench for the text formatter
// Drives integers with random base, width, precision and flags. An internal
// model of the printf rules predicts the text of all but typed directed rows.
// Directed table first, then random items under several sender idle rates.
// ----------------------------------------------------------------------------
module integer_to_text_formatter_test;
  import itf_pkg::*;

  // flag masks built from the package bit positions
  localparam logic [6:0] FL_ZERO   = 7'd1 << FLAG_ZERO;
  localparam logic [6:0] FL_SIGNED = 7'd1 << FLAG_SIGNED;
  localparam logic [6:0] FL_PLUS   = 7'd1 << FLAG_PLUS;
  localparam logic [6:0] FL_SPACE  = 7'd1 << FLAG_SPACE;
  localparam logic [6:0] FL_LEFT   = 7'd1 << FLAG_LEFT;
  localparam logic [6:0] FL_PREFIX = 7'd1 << FLAG_PREFIX;
  localparam logic [6:0] FL_LOWER  = 7'd1 << FLAG_LOWER;

  localparam string UPPER_GLYPHS = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
  localparam string LOWER_GLYPHS = "0123456789abcdefghijklmnopqrstuvwxyz";

  localparam int DIRECTED_ROWS   = 25;
  localparam int RANDOM_PER_RATE = 107;
  // settle time after the last expected character
  localparam int DRAIN_CYCLES    = 400;

  typedef struct packed {
    logic [31:0] value;
    logic [5:0]  base;
    logic [5:0]  width;
    logic [5:0]  precision;
    logic [6:0]  flags;
  } num_item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
    logic       bad_base;
  } text_char_t;

  // one directed row; 'typed' rows carry their expected text literally
  typedef struct {
    num_item_t item;
    bit        typed;
    bit        bad;
    string     text;
  } directed_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [31:0] value_i;
  logic [5:0]  base_i;
  logic [5:0]  width_i;
  logic [5:0]  precision_i;
  logic [6:0]  format_flags_i;
  logic        valid_o;
  logic [7:0]  character_o;
  logic        last_o;
  logic        bad_base_o;

  // characters still owed by the block, oldest first
  text_char_t expected_text[$];
  int         mismatch_count = 0;

  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    // after reset: zero prints one digit
    '{'{32'd0, 6'd10, 6'd0, 6'd0, 7'd0}, 1'b1, 1'b0, "0"},
    // value extremes
    '{'{32'hFFFF_FFFF, 6'd16, 6'd0, 6'd0, 7'd0}, 1'b1, 1'b0, "FFFFFFFF"},
    '{'{32'hFFFF_FFFF, 6'd16, 6'd0, 6'd0, FL_PREFIX | FL_LOWER}, 1'b1, 1'b0, "0xffffffff"},
    '{'{32'h8000_0000, 6'd10, 6'd0, 6'd0, FL_SIGNED}, 1'b1, 1'b0, "-2147483648"},
    '{'{32'hFFFF_FFFF, 6'd10, 6'd0, 6'd0, 7'd0}, 1'b1, 1'b0, "4294967295"},
    '{'{32'hFFFF_FFFF, 6'd2, 6'd0, 6'd0, 7'd0}, 1'b0, 1'b0, ""},
    // bad bases on both sides of the legal range
    '{'{32'd5, 6'd0, 6'd0, 6'd0, 7'd0}, 1'b1, 1'b1, ""},
    '{'{32'd5, 6'd1, 6'd0, 6'd0, 7'd0}, 1'b1, 1'b1, ""},
    '{'{32'hFFFF_FFFF, 6'd37, 6'd63, 6'd63, 7'h7F}, 1'b1, 1'b1, ""},
    '{'{32'd0, 6'd63, 6'd0, 6'd0, 7'd0}, 1'b1, 1'b1, ""},
    '{'{32'hFFFF_FFFF, 6'd36, 6'd0, 6'd0, 7'd0}, 1'b0, 1'b0, ""},
    // octal prefix still goes out for zero
    '{'{32'd0, 6'd8, 6'd0, 6'd0, FL_PREFIX}, 1'b1, 1'b0, "00"},
    // left justify overrides zero pad
    '{'{32'd42, 6'd10, 6'd8, 6'd0, FL_ZERO | FL_LEFT}, 1'b1, 1'b0, "42      "},
    '{'{32'd5, 6'd10, 6'd0, 6'd0, FL_PLUS}, 1'b1, 1'b0, "+5"},
    '{'{32'd5, 6'd10, 6'd0, 6'd0, FL_SPACE}, 1'b1, 1'b0, " 5"},
    '{'{32'd5, 6'd10, 6'd0, 6'd0, FL_PLUS | FL_SPACE}, 1'b0, 1'b0, ""},
    '{'{32'd255, 6'd16, 6'd8, 6'd0, FL_PREFIX | FL_ZERO}, 1'b0, 1'b0, ""},
    // width and precision above the field limit saturate
    '{'{32'd7, 6'd10, 6'd63, 6'd63, 7'd0}, 1'b0, 1'b0, ""},
    // longest text: sign, hex prefix and full precision
    '{'{32'hFFFF_FFFF, 6'd16, 6'd63, 6'd63, FL_SIGNED | FL_PREFIX | FL_ZERO},
      1'b0, 1'b0, ""},
    '{'{32'd123, 6'd10, 6'd10, 6'd0, 7'd0}, 1'b0, 1'b0, ""},
    '{'{32'd123, 6'd10, 6'd10, 6'd5, FL_LEFT | FL_PLUS}, 1'b0, 1'b0, ""},
    '{'{32'h7FFF_FFFF, 6'd3, 6'd0, 6'd0, FL_SIGNED}, 1'b0, 1'b0, ""},
    // prefix ignored outside bases 8 and 16
    '{'{32'd9, 6'd10, 6'd0, 6'd0, FL_PREFIX}, 1'b1, 1'b0, "9"},
    '{'{32'h8000_0000, 6'd16, 6'd20, 6'd3, 7'h7F}, 1'b0, 1'b0, ""},
    '{'{32'd1, 6'd2, 6'd1, 6'd0, 7'd0}, 1'b1, 1'b0, "1"}
  };

  integer_to_text_formatter uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .value_i        (value_i),
    .base_i         (base_i),
    .width_i        (width_i),
    .precision_i    (precision_i),
    .format_flags_i (format_flags_i),
    .valid_o        (valid_o),
    .character_o    (character_o),
    .last_o         (last_o),
    .bad_base_o     (bad_base_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Work out the printf text for one item and queue it, one entry per
  // character. Layout: leading spaces, sign, prefix, zero pad, precision
  // zeros, digits, trailing spaces.
  function automatic void predict_text(input num_item_t it);
    logic [31:0] mag;
    logic [6:0]  fl;
    logic [7:0]  sign_ch;
    logic [7:0]  pad_ch;
    logic [7:0]  digits[$];
    logic [7:0]  line[$];
    string       glyphs;
    int          field;
    int          min_digits;
    int          fill;
    int          n;

    if (it.base < BASE_MIN || it.base > BASE_MAX) begin
      expected_text.push_back('{CHAR_NUL, 1'b1, 1'b1});
      return;
    end
    fl = it.flags;
    glyphs = fl[FLAG_LOWER] ? LOWER_GLYPHS : UPPER_GLYPHS;
    field = (it.width > MAX_FIELD_DEF) ? MAX_FIELD_DEF : int'(it.width);
    min_digits = (it.precision > MAX_FIELD_DEF) ? MAX_FIELD_DEF : int'(it.precision);
    if (fl[FLAG_LEFT]) fl[FLAG_ZERO] = 1'b0;
    pad_ch = fl[FLAG_ZERO] ? CHAR_ZERO : CHAR_SPACE;

    // sign from the top bit; negation gives the true magnitude of the minimum
    mag = it.value;
    sign_ch = CHAR_NUL;
    if (fl[FLAG_SIGNED] && it.value[VALUE_BITS_DEF-1]) begin
      sign_ch = CHAR_MINUS;
      mag = -it.value;
    end else if (fl[FLAG_PLUS]) begin
      sign_ch = CHAR_PLUS;
    end else if (fl[FLAG_SPACE]) begin
      sign_ch = CHAR_SPACE;
    end
    if (sign_ch != CHAR_NUL && field > 0) field--;
    if (fl[FLAG_PREFIX]) begin
      if (it.base == BASE_HEX && field >= 2) field -= 2;
      else if (it.base == BASE_OCT && field > 0) field--;
    end

    // digits, least significant first
    do begin
      digits.push_back(glyphs[int'(mag % it.base)]);
      mag = mag / it.base;
    end while (mag != 0);
    if (digits.size() > min_digits) min_digits = digits.size();
    fill = (field > min_digits) ? field - min_digits : 0;

    // each pad stage consumes the fill, so at most one of them emits
    if (!fl[FLAG_ZERO] && !fl[FLAG_LEFT]) begin
      repeat (fill) line.push_back(CHAR_SPACE);
      fill = 0;
    end
    if (sign_ch != CHAR_NUL) line.push_back(sign_ch);
    if (fl[FLAG_PREFIX] && (it.base == BASE_OCT || it.base == BASE_HEX)) begin
      line.push_back(CHAR_ZERO);
      if (it.base == BASE_HEX) line.push_back(glyphs[PREFIX_X_DIGIT]);
    end
    if (!fl[FLAG_LEFT]) begin
      repeat (fill) line.push_back(pad_ch);
      fill = 0;
    end
    repeat (min_digits - digits.size()) line.push_back(CHAR_ZERO);
    while (digits.size() != 0) line.push_back(digits.pop_back());
    repeat (fill) line.push_back(CHAR_SPACE);

    // overlong text is cut at the output limit, last on the final kept char
    n = (line.size() > MAX_OUT) ? MAX_OUT : line.size();
    for (int k = 0; k < n; k++) expected_text.push_back('{line[k], k == n - 1, 1'b0});
  endfunction

  // Mostly legal bases and small sizes; a few bad bases and saturating sizes.
  function automatic num_item_t random_item();
    num_item_t it;
    case ($urandom_range(9))
      0: it.value = 32'd0;
      1: it.value = $urandom_range(15);
      2, 3: it.value = $urandom_range(9999);
      4: it.value = $urandom | 32'h8000_0000;
      5: it.value = 32'h7FFF_FFFF + $urandom_range(2);
      default: it.value = $urandom;
    endcase
    case ($urandom_range(19))
      0, 1: it.base = $urandom_range(1) ? 6'($urandom_range(1)) : 6'($urandom_range(63, 37));
      2, 3, 4: it.base = BASE_HEX;
      5, 6: it.base = BASE_OCT;
      7, 8, 9: it.base = 6'd10;
      10: it.base = BASE_MIN;
      11: it.base = BASE_MAX;
      default: it.base = 6'($urandom_range(36, 2));
    endcase
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: it.width = 6'($urandom_range(12));
      6, 7, 8: it.width = 6'($urandom_range(40));
      default: it.width = 6'($urandom_range(63));
    endcase
    case ($urandom_range(9))
      0, 1, 2, 3: it.precision = 6'd0;
      4, 5, 6: it.precision = 6'($urandom_range(8));
      7, 8: it.precision = 6'($urandom_range(40));
      default: it.precision = 6'($urandom_range(63));
    endcase
    it.flags = 7'($urandom_range(127));
    return it;
  endfunction

  // Present one item until the block takes it. Start is re-drawn every cycle
  // so that gaps also fall on the cycle where busy drops. Start is left as
  // is after acceptance; the next call or the main flow sets it once.
  task automatic offer_item(input num_item_t it, input int idle_pct);
    bit taken;
    value_i        <= it.value;
    base_i         <= it.base;
    width_i        <= it.width;
    precision_i    <= it.precision;
    format_flags_i <= it.flags;
    taken = 1'b0;
    while (!taken) begin
      start_i <= ($urandom_range(99) >= idle_pct);
      @(posedge clk_i);
      taken = start_i && !busy_o;
    end
  endtask

  // Output checker: results cannot be held off, so every strobe is compared
  // against the oldest expected character.
  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni && valid_o) begin
      if (expected_text.size() == 0) begin
        $display("%0t: unexpected char %h last %b bad_base %b",
                 $time, character_o, last_o, bad_base_o);
        mismatch_count++;
      end else begin
        want = expected_text.pop_front();
        if (character_o !== want.character || last_o !== want.last ||
            bad_base_o !== want.bad_base) begin
          $display("%0t: expected char %h last %b bad_base %b, got char %h last %b bad_base %b",
                   $time, want.character, want.last, want.bad_base,
                   character_o, last_o, bad_base_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int idle_rates[3];
    num_item_t it;

    idle_rates = '{0, 49, 34};
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    value_i        = '0;
    base_i         = '0;
    width_i        = '0;
    precision_i    = '0;
    format_flags_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, back to back
    foreach (directed_rows[r]) begin
      offer_item(directed_rows[r].item, 0);
      if (!directed_rows[r].typed) begin
        predict_text(directed_rows[r].item);
      end else if (directed_rows[r].bad) begin
        expected_text.push_back('{CHAR_NUL, 1'b1, 1'b1});
      end else begin
        for (int k = 0; k < directed_rows[r].text.len(); k++) begin
          expected_text.push_back('{directed_rows[r].text[k],
                                    k == directed_rows[r].text.len() - 1, 1'b0});
        end
      end
    end

    // random items, one block per sender idle rate
    foreach (idle_rates[p]) begin
      repeat (RANDOM_PER_RATE) begin
        it = random_item();
        offer_item(it, idle_rates[p]);
        predict_text(it);
      end
    end
    start_i <= 1'b0;

    while (expected_text.size() != 0) @(posedge clk_i);
    // catch stray strobes after the final expected character
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog: far above the slowest legal run
  initial begin
    #8000000;
    $display("FAILURE");
    $finish;
  end

endmodule
